/* rtl/core/ffha_pkg.sv */
// shared types, constants and codes of the first-fit heap allocator
package ffha_pkg;

	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned SIZE_W   = 24;
	localparam int unsigned HEAP_W   = 25;
	localparam int unsigned HDR_W    = 6;
	localparam int unsigned OP_W     = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned PADDR_W  = 4;
	localparam int unsigned PDATA_W  = 32;

	localparam int unsigned DEF_MAX_SEGMENTS = 64;

	localparam logic [ADDR_W-1:0] RST_HEAP_BASE    = '0;
	localparam logic [HEAP_W-1:0] RST_HEAP_BYTES   = HEAP_W'(1024 * 1024 * 4);
	localparam logic [HDR_W-1:0]  RST_HEADER_BYTES = HDR_W'(12);
	localparam logic [SIZE_W-1:0] RST_FIRST_SIZE   =
		SIZE_W'(1024 * 1024 * 4 - 12);

	typedef enum logic [OP_W-1:0] {
		OP_INIT  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_NO_FIT   = 2'd1,
		STATUS_BAD_FREE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		REG_HEAP_BASE    = 2'd0,
		REG_HEAP_BYTES   = 2'd1,
		REG_HEADER_BYTES = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [ADDR_W-1:0] heap_base;
		logic [HEAP_W-1:0] heap_bytes;
		logic [HDR_W-1:0]  header_bytes;
	} cfg_t;

	typedef struct packed {
		logic [OP_W-1:0]   opcode;
		logic [SIZE_W-1:0] request_size;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [ADDR_W-1:0]   result_address;
		logic [STATUS_W-1:0] status;
	} rsp_t;

endpackage

/* rtl/core/ffha_if.sv */
// request and result channel interfaces of the heap allocator
interface ffha_req_if import ffha_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [SIZE_W-1:0] request_size;
	logic [ADDR_W-1:0] address;

	modport source (output valid, output opcode, output request_size, output address,
		input ready);
	modport sink (input valid, input opcode, input request_size, input address,
		output ready);
endinterface

interface ffha_rsp_if import ffha_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   result_address;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output result_address, output status, input ready);
	modport sink (input valid, input result_address, input status, output ready);
endinterface

/* rtl/core/ffha_walker.sv */
// segment table memory and chain walking sequencer of the heap allocator
module ffha_walker import ffha_pkg::*; #(
	parameter int unsigned MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic req_valid,
	input  req_t req_data,
	output logic req_ready,
	output logic rsp_valid,
	output rsp_t rsp_data,
	input  logic rsp_take
);

	localparam int unsigned IDX_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int unsigned USED_W = $clog2(MAX_SEGMENTS + 1);
	localparam logic [USED_W-1:0] USED_FULL = USED_W'(MAX_SEGMENTS);

	typedef struct packed {
		logic [SIZE_W-1:0] size;
		logic              free;
		logic [IDX_W-1:0]  link;
		logic              link_valid;
	} entry_t;

	typedef enum logic [4:0] {
		ST_INIT  = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_WALK  = 5'b00100,
		ST_SPLIT = 5'b01000,
		ST_RESP  = 5'b10000
	} state_t;

	entry_t seg_mem_q [MAX_SEGMENTS];
	entry_t rd_entry_q;

	state_t              state_q, state_d;
	logic                alloc_q, alloc_d;
	logic [SIZE_W-1:0]   size_q, size_d;
	logic [ADDR_W-1:0]   addr_q, addr_d;
	logic [IDX_W-1:0]    cur_q, cur_d;
	logic [ADDR_W-1:0]   pa_q, pa_d;
	logic [USED_W-1:0]   used_q, used_d;
	logic [ADDR_W-1:0]   res_addr_q, res_addr_d;
	logic [STATUS_W-1:0] res_status_q, res_status_d;

	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_entry;

	logic              req_fire;
	logic [HEAP_W-1:0] first_diff;
	logic [SIZE_W-1:0] first_size;
	logic [HEAP_W-1:0] need;
	logic              fit;
	logic              can_split;
	logic              match;
	logic [ADDR_W-1:0] pa_next;

	assign req_ready = (state_q == ST_IDLE);
	assign req_fire  = req_valid && req_ready;
	assign rsp_valid = (state_q == ST_RESP);
	assign rsp_data  = '{result_address: res_addr_q, status: res_status_q};

	// first segment after a rebuild, saturated to the size field
	assign first_diff = cfg.heap_bytes - HEAP_W'(cfg.header_bytes);
	assign first_size = (cfg.heap_bytes <= HEAP_W'(cfg.header_bytes)) ? '0 :
		(first_diff[HEAP_W-1] ? '1 : first_diff[SIZE_W-1:0]);

	assign need      = HEAP_W'(size_q) + HEAP_W'(cfg.header_bytes);
	assign fit       = rd_entry_q.free && (rd_entry_q.size >= size_q);
	assign can_split = (HEAP_W'(rd_entry_q.size) > need) && (used_q != USED_FULL);
	assign match     = (pa_q == addr_q);
	assign pa_next   = pa_q + ADDR_W'(rd_entry_q.size) + ADDR_W'(cfg.header_bytes);

	always_comb begin
		state_d      = state_q;
		alloc_d      = alloc_q;
		size_d       = size_q;
		addr_d       = addr_q;
		cur_d        = cur_q;
		pa_d         = pa_q;
		used_d       = used_q;
		res_addr_d   = res_addr_q;
		res_status_d = res_status_q;
		rd_en        = 1'b0;
		rd_addr      = '0;
		wr_en        = 1'b0;
		wr_addr      = cur_q;
		wr_entry     = rd_entry_q;
		unique case (state_q)
			ST_INIT: begin
				wr_en    = 1'b1;
				wr_addr  = '0;
				wr_entry = '{size: RST_FIRST_SIZE, free: 1'b1, link: '0, link_valid: 1'b0};
				state_d  = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_fire) begin
					alloc_d      = (req_data.opcode == OP_ALLOC);
					size_d       = req_data.request_size;
					addr_d       = req_data.address;
					cur_d        = '0;
					pa_d         = cfg.heap_base + ADDR_W'(cfg.header_bytes);
					res_addr_d   = '0;
					res_status_d = STATUS_OK;
					state_d      = ST_RESP;
					priority if (req_data.opcode == OP_INIT) begin
						wr_en    = 1'b1;
						wr_addr  = '0;
						wr_entry = '{size: first_size, free: 1'b1, link: '0,
							link_valid: 1'b0};
						used_d   = USED_W'(1);
					end else if (req_data.opcode == OP_ALLOC) begin
						if (req_data.request_size == '0) begin
							res_status_d = STATUS_NO_FIT;
						end else begin
							rd_en   = 1'b1;
							state_d = ST_WALK;
						end
					end else if (req_data.opcode == OP_FREE) begin
						if (req_data.address != '0) begin
							rd_en   = 1'b1;
							state_d = ST_WALK;
						end
					end else begin
						// unused opcode, answered as ok
					end
				end
			end
			ST_WALK: begin
				priority if (alloc_q && fit) begin
					wr_en      = 1'b1;
					res_addr_d = pa_q;
					if (can_split) begin
						// remainder goes to the next unused entry, current entry next cycle
						wr_addr  = used_q[IDX_W-1:0];
						wr_entry = '{size: rd_entry_q.size - need[SIZE_W-1:0], free: 1'b1,
							link: rd_entry_q.link, link_valid: rd_entry_q.link_valid};
						state_d  = ST_SPLIT;
					end else begin
						wr_entry.free = 1'b0;
						state_d       = ST_RESP;
					end
				end else if (!alloc_q && match) begin
					wr_en         = 1'b1;
					wr_entry.free = 1'b1;
					state_d       = ST_RESP;
				end else if (!rd_entry_q.link_valid) begin
					res_addr_d   = '0;
					res_status_d = alloc_q ? STATUS_NO_FIT : STATUS_BAD_FREE;
					state_d      = ST_RESP;
				end else begin
					rd_en   = 1'b1;
					rd_addr = rd_entry_q.link;
					cur_d   = rd_entry_q.link;
					pa_d    = pa_next;
				end
			end
			ST_SPLIT: begin
				wr_en    = 1'b1;
				wr_entry = '{size: size_q, free: 1'b0, link: used_q[IDX_W-1:0],
					link_valid: 1'b1};
				used_d   = used_q + USED_W'(1);
				state_d  = ST_RESP;
			end
			ST_RESP: begin
				if (rsp_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			used_q  <= USED_W'(1);
			cur_q   <= '0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			cur_q   <= cur_d;
		end
	end

	always_ff @(posedge clk) begin
		alloc_q      <= alloc_d;
		size_q       <= size_d;
		addr_q       <= addr_d;
		pa_q         <= pa_d;
		res_addr_q   <= res_addr_d;
		res_status_q <= res_status_d;
	end

	// segment table
	always_ff @(posedge clk) begin
		if (wr_en) begin
			seg_mem_q[wr_addr] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry_q <= seg_mem_q[rd_addr];
		end
	end

`ifndef SYNTHESIS
	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q != '0 && used_q <= USED_FULL)
		else $error("segment count out of range");

	a_walk_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> USED_W'(cur_q) < used_q)
		else $error("walk reached an entry beyond the table fill");

	a_split_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SPLIT |-> $past(state_q) == ST_WALK && $past(alloc_q))
		else $error("split without an allocate walk");

	a_split_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SPLIT |=> used_q == $past(used_q) + USED_W'(1))
		else $error("split did not take a new entry");
`endif

endmodule

/* rtl/core/first_fit_heap_allocator_core.sv */
// top level of the first-fit heap allocator: register port, result register, walker
// The heap is kept as an address-ordered chain of segments in a single table memory of
// MAX_SEGMENTS entries, one read and one write port, read data registered. One request is
// handled at a time. Reinitialize, zero-size allocate, null free and unused opcodes go
// straight from acceptance to presenting the result. Allocate and free walk the chain
// from entry 0 at one segment per cycle, visiting at most MAX_SEGMENTS segments; an
// allocate that splits a segment passes through a split state for the second table write.
// The result sits in an output register, so the next request is accepted while the
// previous result waits. After reset an init state writes the initial segment before the
// first request is accepted. Register writes do not rebuild the chain: only the
// reinitialize opcode does.
module first_fit_heap_allocator_core import ffha_pkg::*; #(
	parameter int unsigned MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	ffha_req_if.sink           req,
	ffha_rsp_if.source         rsp
);

	cfg_t cfg_q;
	logic cfg_wr;
	logic walk_rsp_valid;
	rsp_t walk_rsp;
	logic rsp_take;
	logic rsp_valid_q;
	rsp_t rsp_data_q;
	req_t req_data;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heap_base    <= RST_HEAP_BASE;
			cfg_q.heap_bytes   <= RST_HEAP_BYTES;
			cfg_q.header_bytes <= RST_HEADER_BYTES;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_HEAP_BASE:    cfg_q.heap_base    <= pwdata[ADDR_W-1:0];
				REG_HEAP_BYTES:   cfg_q.heap_bytes   <= pwdata[HEAP_W-1:0];
				REG_HEADER_BYTES: cfg_q.header_bytes <= pwdata[HDR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_HEAP_BASE:    prdata = PDATA_W'(cfg_q.heap_base);
			REG_HEAP_BYTES:   prdata = PDATA_W'(cfg_q.heap_bytes);
			REG_HEADER_BYTES: prdata = PDATA_W'(cfg_q.header_bytes);
			default:          prdata = '0;
		endcase
	end

	assign req_data = '{opcode: req.opcode, request_size: req.request_size,
		address: req.address};

	ffha_walker #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.req_valid (req.valid),
		.req_data  (req_data),
		.req_ready (req.ready),
		.rsp_valid (walk_rsp_valid),
		.rsp_data  (walk_rsp),
		.rsp_take  (rsp_take)
	);

	// output register frees the walker while a result waits
	assign rsp_take = walk_rsp_valid && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_take) begin
			rsp_data_q <= walk_rsp;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.result_address = rsp_data_q.result_address;
	assign rsp.status         = rsp_data_q.status;

endmodule

/* test/first_fit_heap_allocator_checker.sv */
`timescale 1ns / 100ps
// checker for the heap allocator: predicts each request's result and compares it on the way out
module first_fit_heap_allocator_checker import ffha_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	ffha_req_if                req,
	ffha_rsp_if                rsp,
	output int                 failures
);

	localparam int unsigned SEGS  = DEF_MAX_SEGMENTS;
	localparam int unsigned IDX_W = $clog2(SEGS);
	localparam longint SIZE_LIMIT = longint'((64'd1 << SIZE_W) - 64'd1);

	cfg_t              cfg;
	logic [SIZE_W-1:0] seg_size   [SEGS];
	logic              seg_free   [SEGS];
	logic [IDX_W-1:0]  seg_next   [SEGS];
	logic              seg_linked [SEGS];
	int unsigned       seg_count;
	rsp_t              pending_results [$];
	rsp_t              due_result;
	int                mismatches;

	function automatic void rebuild_chain();
		longint            span;
		logic [SIZE_W-1:0] first;
		span = longint'(cfg.heap_bytes) - longint'(cfg.header_bytes);
		first = '0;
		if (span > SIZE_LIMIT) begin
			first = '1;
		end else if (span > 0) begin
			first = SIZE_W'(span);
		end
		for (int i = 0; i < SEGS; i++) begin
			seg_size[i]   = '0;
			seg_free[i]   = 1'b0;
			seg_next[i]   = '0;
			seg_linked[i] = 1'b0;
		end
		seg_size[0] = first;
		seg_free[0] = 1'b1;
		seg_count   = 1;
	endfunction

	function automatic logic [ADDR_W-1:0] payload_address(logic [63:0] offset);
		return ADDR_W'(64'(cfg.heap_base) + offset + 64'(cfg.header_bytes));
	endfunction

	function automatic rsp_t walk_alloc(logic [SIZE_W-1:0] size);
		rsp_t             r;
		logic [IDX_W-1:0] cur;
		logic [63:0]      offset;
		logic [63:0]      need;
		int unsigned      n;
		r.result_address = '0;
		r.status         = STATUS_NO_FIT;
		if (size == '0) return r;
		cur    = '0;
		offset = '0;
		for (int step = 0; step < SEGS; step++) begin
			if (seg_free[cur] && seg_size[cur] >= size) begin
				need = 64'(size) + 64'(cfg.header_bytes);
				// split only while the table has room
				if (64'(seg_size[cur]) > need && seg_count < SEGS) begin
					n             = seg_count;
					seg_size[n]   = SIZE_W'(64'(seg_size[cur]) - need);
					seg_free[n]   = 1'b1;
					seg_next[n]   = seg_next[cur];
					seg_linked[n] = seg_linked[cur];
					seg_size[cur]   = size;
					seg_next[cur]   = IDX_W'(n);
					seg_linked[cur] = 1'b1;
					seg_count       = n + 1;
				end
				seg_free[cur]    = 1'b0;
				r.result_address = payload_address(offset);
				r.status         = STATUS_OK;
				return r;
			end
			if (!seg_linked[cur]) return r;
			offset = offset + 64'(seg_size[cur]) + 64'(cfg.header_bytes);
			cur    = seg_next[cur];
		end
		return r;
	endfunction

	function automatic rsp_t walk_free(logic [ADDR_W-1:0] addr);
		rsp_t             r;
		logic [IDX_W-1:0] cur;
		logic [63:0]      offset;
		r.result_address = '0;
		r.status         = STATUS_OK;
		if (addr == '0) return r;
		cur    = '0;
		offset = '0;
		for (int step = 0; step < SEGS; step++) begin
			if (payload_address(offset) == addr) begin
				seg_free[cur] = 1'b1;
				return r;
			end
			if (!seg_linked[cur]) break;
			offset = offset + 64'(seg_size[cur]) + 64'(cfg.header_bytes);
			cur    = seg_next[cur];
		end
		r.status = STATUS_BAD_FREE;
		return r;
	endfunction

	function automatic rsp_t predict(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size,
		logic [ADDR_W-1:0] addr);
		rsp_t r;
		r.result_address = '0;
		r.status         = STATUS_OK;
		case (op)
			OP_INIT: begin
				rebuild_chain();
			end
			OP_ALLOC: begin
				r = walk_alloc(size);
			end
			OP_FREE: begin
				r = walk_free(addr);
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.heap_base    = RST_HEAP_BASE;
			cfg.heap_bytes   = RST_HEAP_BYTES;
			cfg.header_bytes = RST_HEADER_BYTES;
			rebuild_chain();
			pending_results.delete();
			mismatches = 0;
			failures   = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[PADDR_W-1:2]))
					REG_HEAP_BASE:    cfg.heap_base    = pwdata;
					REG_HEAP_BYTES:   cfg.heap_bytes   = HEAP_W'(pwdata);
					REG_HEADER_BYTES: cfg.header_bytes = HDR_W'(pwdata);
					default: begin
					end
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (pending_results.size() == 0) begin
					mismatches++;
					$display("%0t: result with no request waiting: address %h status %0d",
						$time, rsp.result_address, rsp.status);
				end else begin
					due_result = pending_results.pop_front();
					if (rsp.result_address !== due_result.result_address) begin
						mismatches++;
						$display("%0t: result_address expected %h got %h", $time,
							due_result.result_address, rsp.result_address);
					end
					if (rsp.status !== due_result.status) begin
						mismatches++;
						$display("%0t: status expected %0d got %0d", $time,
							due_result.status, rsp.status);
					end
				end
			end
			if (req.valid && req.ready) begin
				pending_results.push_back(predict(req.opcode, req.request_size, req.address));
			end
			failures = mismatches + pending_results.size();
		end
	end

endmodule

/* test/first_fit_heap_allocator_core_tb.sv */
`timescale 1ns / 100ps
// testbench top for the heap allocator: clock, reset, register writes and request traffic
module first_fit_heap_allocator_core_tb;
	import ffha_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int ITEMS_PER_PHASE = 310;
	localparam int PHASES          = 6;
	localparam int HOLD_AT         = 300;
	localparam int HOLD_CYCLES     = 400;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int                failures;
	int unsigned       issued;
	int unsigned       answered;
	logic [ADDR_W-1:0] granted [$];
	logic [HEAP_W-1:0] heap_now;
	bit                quiet;
	int                init_pct;
	bit                held;

	ffha_req_if req_ch ();
	ffha_rsp_if rsp_ch ();

	first_fit_heap_allocator_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.rsp     (rsp_ch)
	);

	first_fit_heap_allocator_checker chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.pready   (pready),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.failures (failures)
	);

	always #1 clk = ~clk;

	initial begin
		#3_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 60) return 0;
		if (roll < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send(logic [OP_W-1:0] op, logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
		int gap;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid        = 1'b1;
		req_ch.opcode       = op;
		req_ch.request_size = size;
		req_ch.address      = addr;
		if (op == OP_INIT) granted.delete();
		do @(posedge clk); while (!req_ch.ready);
		issued++;
	endtask

	task automatic settle();
		@(negedge clk);
		req_ch.valid = 1'b0;
		while (answered != issued) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic configure(logic [ADDR_W-1:0] base, logic [HEAP_W-1:0] bytes,
		logic [HDR_W-1:0] hdr);
		settle();
		write_reg(REG_HEAP_BASE, base);
		write_reg(REG_HEAP_BYTES, PDATA_W'(bytes));
		write_reg(REG_HEADER_BYTES, PDATA_W'(hdr));
		heap_now = bytes;
	endtask

	task automatic random_item();
		int                roll;
		int                kind;
		logic [OP_W-1:0]   op;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] addr;
		roll = $urandom_range(0, 99);
		kind = $urandom_range(0, 19);
		size = SIZE_W'($urandom);
		addr = $urandom;
		if (roll < init_pct) begin
			op = OP_INIT;
		end else if (roll < 60) begin
			op = OP_ALLOC;
			if (kind < 12) begin
				size = SIZE_W'($urandom_range(1, 64));
			end else if (kind < 16) begin
				size = SIZE_W'($urandom_range(1, heap_now / 8 + 1));
			end else if (kind < 18) begin
				size = SIZE_W'($urandom_range(65, 512));
			end else if (kind == 18) begin
				size = '0;
			end
		end else if (roll < 97) begin
			op = OP_FREE;
			if (granted.size() > 0 && kind < 14) begin
				addr = granted[$urandom_range(0, granted.size() - 1)];
			end else if (granted.size() > 0 && kind < 16) begin
				addr = granted[$urandom_range(0, granted.size() - 1)] + $urandom_range(1, 3);
			end else if (kind == 16) begin
				addr = '0;
			end
		end else begin
			// full-width size, almost never fits
			op = OP_ALLOC;
		end
		send(op, size, addr);
	endtask

	// result side: random stalls, one long hold-off, and a pool of granted addresses
	initial begin
		int stall;
		rsp_ch.ready = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = pick_gap();
			if (!held && answered >= HOLD_AT) begin
				held  = 1'b1;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				rsp_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready = 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			answered++;
			if (rsp_ch.status == STATUS_OK && rsp_ch.result_address != '0) begin
				granted.push_back(rsp_ch.result_address);
				if (granted.size() > 256) void'(granted.pop_front());
			end
		end
	end

	initial begin
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		req_ch.valid        = 1'b0;
		req_ch.opcode       = OP_INIT;
		req_ch.request_size = '0;
		req_ch.address      = '0;
		issued              = 0;
		answered            = 0;
		quiet               = 1'b0;
		init_pct            = 1;
		heap_now            = RST_HEAP_BYTES;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset heap: base 0, 12-byte headers
		send(OP_ALLOC, '0, '0);
		send(OP_ALLOC, 24'd1, '1);
		send(OP_ALLOC, 24'd16, '0);
		send(OP_FREE, '1, 32'd12);
		send(OP_FREE, '0, 32'd12);
		send(OP_FREE, '0, 32'd13);
		send(OP_FREE, '0, '0);
		send(OP_FREE, '0, '1);
		send(OP_ALLOC, 24'd1, '0);
		send(OP_ALLOC, '1, '0);
		send(OP_UNUSED, '1, '1);
		send(OP_INIT, '1, '1);
		send(OP_ALLOC, 24'd4194292, '0);
		send(OP_ALLOC, 24'd1, '0);
		send(OP_FREE, '0, 32'd12);
		send(OP_ALLOC, 24'd4194279, '0);
		send(OP_ALLOC, 24'd1, '0);

		// grants that wrap past the top of the address space
		configure(32'hFFFF_FFF4, 25'd64, 6'd12);
		send(OP_INIT, '0, '0);
		send(OP_ALLOC, 24'd4, '0);
		send(OP_FREE, '0, '0);
		send(OP_ALLOC, 24'd4, '0);
		send(OP_FREE, '0, 32'd16);
		send(OP_ALLOC, 24'd100, '0);

		// heap no larger than a header
		configure(32'h0, 25'd20, 6'd32);
		send(OP_INIT, '0, '0);
		send(OP_ALLOC, 24'd1, '0);

		// first segment size saturates
		configure(32'h8000_0000, 25'h1FF_FFFF, 6'd4);
		send(OP_INIT, '0, '0);
		send(OP_ALLOC, '1, '0);

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: configure(32'h0010_0000, RST_HEAP_BYTES, RST_HEADER_BYTES);
				1: configure('1, 25'd16777216, 6'd32);
				2: configure($urandom, 25'd64, 6'd4);
				3: configure($urandom, HEAP_W'($urandom_range(64, 16777216)),
					HDR_W'($urandom_range(4, 32)));
				4: configure($urandom, HEAP_W'($urandom_range(1024, 8192)),
					HDR_W'($urandom_range(4, 32)));
				default: configure('0, HEAP_W'($urandom_range(64, 65536)),
					HDR_W'($urandom_range(4, 32)));
			endcase
			quiet    = (phase == 0);
			init_pct = (phase == 0) ? 0 : 1;
			// last phase keeps the old chain under the new registers
			if (phase != PHASES - 1) send(OP_INIT, '0, '0);
			repeat (ITEMS_PER_PHASE) random_item();
		end

		settle();
		repeat (70) @(posedge clk);
		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

/* first_fit_heap_allocator_core.f */
rtl/core/ffha_pkg.sv
rtl/core/ffha_if.sv
rtl/core/ffha_walker.sv
rtl/core/first_fit_heap_allocator_core.sv
test/first_fit_heap_allocator_checker.sv
test/first_fit_heap_allocator_core_tb.sv
